FILE: src/tdma_coordinator_mac_engine_macros.svh
// ----------------------------------------------------------------------------
// TDMA coordinator MAC assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TDMA_COORDINATOR_MAC_ENGINE_MACROS_SVH
`define TDMA_COORDINATOR_MAC_ENGINE_MACROS_SVH

// property must hold at every edge out of reset
`define TDMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true out of reset
`define TDMA_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: src/tdma_pkg.sv
// ----------------------------------------------------------------------------
// TDMA coordinator MAC package
// Shared types, codes, frame layout constants and CRC helper.
// ----------------------------------------------------------------------------
package tdma_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_FCF       = 3'd0;
  localparam logic [2:0] REG_DEST_PAN  = 3'd1;
  localparam logic [2:0] REG_OWN_PAN   = 3'd2;
  localparam logic [2:0] REG_OWN_ADDR  = 3'd3;
  localparam logic [2:0] REG_SUPERFRM  = 3'd4;
  localparam logic [2:0] REG_SLOT_TOT  = 3'd5;
  localparam logic [2:0] REG_LATE_LIM  = 3'd6;
  localparam logic [2:0] REG_FIRST_SEQ = 3'd7;

  localparam logic ACT_BEACON  = 1'b0;
  localparam logic KIND_BEACON = 1'b0;
  localparam logic KIND_ASSOC  = 1'b1;

  localparam logic [7:0]  BEACON_CODE     = 8'd0;
  localparam logic [7:0]  ASSOC_CODE      = 8'd2;
  localparam logic [7:0]  REQUEST_CODE    = 8'd3;
  localparam logic [7:0]  MIN_REQUEST_LEN = 8'd13;
  localparam logic [7:0]  FIRST_SLOT      = 8'd10;
  localparam logic [7:0]  SLOT_STEP       = 8'd5;
  localparam logic [15:0] BROADCAST       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h8408;

  localparam logic [7:0] RX_TYPE_POS = 8'd1;
  localparam logic [7:0] RX_REQ_LO   = 8'd11;
  localparam logic [7:0] RX_REQ_HI   = 8'd12;

  // bytes before the CRC
  localparam logic [4:0] BEACON_BODY = 5'd18;
  localparam logic [4:0] ASSOC_BODY  = 5'd12;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  frame_control_byte;
    logic [15:0] dest_pan_id;
    logic [15:0] own_pan_id;
    logic [15:0] own_short_addr;
    logic [15:0] superframe_length;
    logic [7:0]  slot_total;
    logic [31:0] late_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  seq;
    logic [31:0] stamp;
    logic [15:0] requester;
    logic [7:0]  slot;
    logic [15:0] good;
    logic [15:0] bad;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb = b[k] ^ c[0];
      c  = {1'b0, c[15:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

FILE: src/tdma_if.sv
// ----------------------------------------------------------------------------
// TDMA coordinator MAC channel interfaces
// Input item channel and output frame byte channel, valid/ready.
// ----------------------------------------------------------------------------
interface tdma_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic [31:0] now_ms;

  modport source (output valid, action, data_byte, frame_end, now_ms, input ready);
  modport sink (input valid, action, data_byte, frame_end, now_ms, output ready);
endinterface

interface tdma_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_kind;
  logic [15:0] frames_counted;
  logic [15:0] crc_failures;

  modport source (output valid, out_byte, out_last, out_kind, frames_counted, crc_failures,
                  input ready);
  modport sink (input valid, out_byte, out_last, out_kind, frames_counted, crc_failures,
                output ready);
endinterface

FILE: src/tdma_coordinator_mac_engine.sv
// ----------------------------------------------------------------------------
// TDMA coordinator MAC engine
// Beacon and association frame generator with request frame checking.
//
//   channel  dir  beat
//   items    in   beacon trigger or one request byte, with time stamp
//   frames   out  one sent frame byte with last mark, kind and counters
//   apb      in   configuration register write/read
//
// One item is taken per cycle while the four-entry job queue has room.
// Each beacon sends 20 beats and each association 14, one beat per cycle
// from the back end serializer unless the output stalls; the output port sets sustained throughput.
// Synchronous reset clears control state; no clearing pass.
// An output stall holds the back end; the front keeps taking items until
// the job queue fills, then drops items.ready.
// ----------------------------------------------------------------------------
module tdma_coordinator_mac_engine (
  input  logic                        clk,
  input  logic                        rst,
  tdma_in_if.sink                     items,
  tdma_out_if.source                  frames,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tdma_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  tdma_pkg::cfg_t cfg;
  tdma_pkg::job_t push_job;
  tdma_pkg::job_t q_data;
  logic           seq_load;
  logic [7:0]     seq_value;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;

  tdma_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .seq_load  (seq_load),
    .seq_value (seq_value)
  );

  tdma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cfg       (cfg),
    .seq_load  (seq_load),
    .seq_value (seq_value),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  tdma_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (push_job),
    .full   (q_full),
    .pop    (pop),
    .rdata  (q_data),
    .rvalid (q_valid)
  );

  tdma_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_data  (q_data),
    .q_valid (q_valid),
    .pop     (pop),
    .frames  (frames)
  );

endmodule

FILE: src/tdma_regs.sv
// ----------------------------------------------------------------------------
// TDMA register file
// APB-style configuration registers; sequence load pulse on first_sequence.
// ----------------------------------------------------------------------------
module tdma_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tdma_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output tdma_pkg::cfg_t              cfg,
  output logic                        seq_load,
  output logic [7:0]                  seq_value
);

  logic [7:0]  first_sequence;
  logic [2:0]  idx;
  logic        wr;

  assign pready    = 1'b1;
  assign idx       = paddr[4:2];
  assign wr        = psel && penable && pwrite;
  assign seq_load  = wr && (idx == tdma_pkg::REG_FIRST_SEQ);
  assign seq_value = pwdata[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg            <= '0;
      first_sequence <= 8'd0;
    end else if (wr) begin
      case (idx)
        tdma_pkg::REG_FCF:       cfg.frame_control_byte <= pwdata[7:0];
        tdma_pkg::REG_DEST_PAN:  cfg.dest_pan_id        <= pwdata[15:0];
        tdma_pkg::REG_OWN_PAN:   cfg.own_pan_id         <= pwdata[15:0];
        tdma_pkg::REG_OWN_ADDR:  cfg.own_short_addr     <= pwdata[15:0];
        tdma_pkg::REG_SUPERFRM:  cfg.superframe_length  <= pwdata[15:0];
        tdma_pkg::REG_SLOT_TOT:  cfg.slot_total         <= pwdata[7:0];
        tdma_pkg::REG_LATE_LIM:  cfg.late_limit_ms      <= pwdata;
        tdma_pkg::REG_FIRST_SEQ: first_sequence         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tdma_pkg::REG_FCF:       prdata = {24'd0, cfg.frame_control_byte};
      tdma_pkg::REG_DEST_PAN:  prdata = {16'd0, cfg.dest_pan_id};
      tdma_pkg::REG_OWN_PAN:   prdata = {16'd0, cfg.own_pan_id};
      tdma_pkg::REG_OWN_ADDR:  prdata = {16'd0, cfg.own_short_addr};
      tdma_pkg::REG_SUPERFRM:  prdata = {16'd0, cfg.superframe_length};
      tdma_pkg::REG_SLOT_TOT:  prdata = {24'd0, cfg.slot_total};
      tdma_pkg::REG_LATE_LIM:  prdata = cfg.late_limit_ms;
      tdma_pkg::REG_FIRST_SEQ: prdata = {24'd0, first_sequence};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/tdma_front.sv
// ----------------------------------------------------------------------------
// TDMA front end
// Takes beacon triggers and request bytes, runs the receive CRC, judges
// request frames and queues frame jobs for the back end.
// ----------------------------------------------------------------------------
module tdma_front (
  input  logic               clk,
  input  logic               rst,
  tdma_in_if.sink            items,
  input  tdma_pkg::cfg_t     cfg,
  input  logic               seq_load,
  input  logic [7:0]         seq_value,
  input  logic               q_full,
  output logic               push,
  output tdma_pkg::job_t     job
);

  logic        beacon_seen, beacon_seen_next;
  logic [31:0] beacon_time, beacon_time_next;
  logic [7:0]  sequence_counter, sequence_counter_next;
  logic [7:0]  next_slot, next_slot_next;
  logic [7:0]  rx_length, rx_length_next;
  logic [15:0] rx_crc, rx_crc_next;
  logic [7:0]  rx_type, rx_type_next;
  logic [15:0] rx_requester, rx_requester_next;
  logic [15:0] good_frames, good_frames_next;
  logic [15:0] bad_frames, bad_frames_next;

  logic        accept;
  logic [15:0] crc_new;
  logic [7:0]  len_new;
  logic [7:0]  type_new;
  logic [15:0] req_new;
  logic [31:0] elapsed;
  logic        timely;

  assign items.ready = !q_full;
  assign accept      = items.valid && items.ready;

  assign crc_new  = tdma_pkg::crc_byte(rx_crc, items.data_byte);
  assign len_new  = (rx_length == 8'hFF) ? rx_length : rx_length + 8'd1;
  assign type_new = (rx_length == tdma_pkg::RX_TYPE_POS) ? items.data_byte : rx_type;
  assign req_new  = (rx_length == tdma_pkg::RX_REQ_LO) ? {rx_requester[15:8], items.data_byte} :
                    (rx_length == tdma_pkg::RX_REQ_HI) ? {items.data_byte, rx_requester[7:0]} :
                    rx_requester;
  assign elapsed  = items.now_ms - beacon_time;
  assign timely   = beacon_seen && (elapsed <= cfg.late_limit_ms);

  always_comb begin
    beacon_seen_next      = beacon_seen;
    beacon_time_next      = beacon_time;
    sequence_counter_next = sequence_counter;
    next_slot_next        = next_slot;
    rx_length_next        = rx_length;
    rx_crc_next           = rx_crc;
    rx_type_next          = rx_type;
    rx_requester_next     = rx_requester;
    good_frames_next      = good_frames;
    bad_frames_next       = bad_frames;
    push                  = 1'b0;
    job                   = '0;
    job.seq               = sequence_counter;
    job.good              = good_frames;
    job.bad               = bad_frames;

    if (accept) begin
      if (items.action == tdma_pkg::ACT_BEACON) begin
        beacon_seen_next      = 1'b1;
        beacon_time_next      = items.now_ms;
        sequence_counter_next = sequence_counter + 8'd1;
        push                  = 1'b1;
        job.kind              = tdma_pkg::KIND_BEACON;
        job.stamp             = items.now_ms;
      end else if (!items.frame_end) begin
        rx_length_next    = len_new;
        rx_crc_next       = crc_new;
        rx_type_next      = type_new;
        rx_requester_next = req_new;
      end else begin
        rx_length_next    = 8'd0;
        rx_crc_next       = 16'd0;
        rx_type_next      = 8'd0;
        rx_requester_next = 16'd0;
        if (timely && (len_new >= tdma_pkg::MIN_REQUEST_LEN)) begin
          good_frames_next = tdma_pkg::sat_inc16(good_frames);
          job.good         = good_frames_next;
          if (crc_new != 16'd0) begin
            bad_frames_next = tdma_pkg::sat_inc16(bad_frames);
          end else if (type_new == tdma_pkg::REQUEST_CODE) begin
            sequence_counter_next = sequence_counter + 8'd1;
            next_slot_next        = next_slot + tdma_pkg::SLOT_STEP;
            push                  = 1'b1;
            job.kind              = tdma_pkg::KIND_ASSOC;
            job.requester         = req_new;
            job.slot              = next_slot;
          end
        end
      end
    end

    if (seq_load) begin
      sequence_counter_next = seq_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beacon_seen      <= 1'b0;
      beacon_time      <= 32'd0;
      sequence_counter <= 8'd0;
      next_slot        <= tdma_pkg::FIRST_SLOT;
      rx_length        <= 8'd0;
      rx_crc           <= 16'd0;
      rx_type          <= 8'd0;
      rx_requester     <= 16'd0;
      good_frames      <= 16'd0;
      bad_frames       <= 16'd0;
    end else begin
      beacon_seen      <= beacon_seen_next;
      beacon_time      <= beacon_time_next;
      sequence_counter <= sequence_counter_next;
      next_slot        <= next_slot_next;
      rx_length        <= rx_length_next;
      rx_crc           <= rx_crc_next;
      rx_type          <= rx_type_next;
      rx_requester     <= rx_requester_next;
      good_frames      <= good_frames_next;
      bad_frames       <= bad_frames_next;
    end
  end

endmodule

FILE: src/tdma_jobq.sv
// ----------------------------------------------------------------------------
// TDMA job queue
// Short register FIFO of frame jobs between front and back end.
// ----------------------------------------------------------------------------
`include "tdma_coordinator_mac_engine_macros.svh"

module tdma_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tdma_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output tdma_pkg::job_t rdata,
  output logic           rvalid
);

  tdma_pkg::job_t                mem [tdma_pkg::QDEPTH];
  logic [tdma_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tdma_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tdma_pkg::QCNT_W-1:0]   count;

  assign full   = (count == tdma_pkg::QCNT_W'(tdma_pkg::QDEPTH));
  assign rvalid = (count != '0);
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TDMA_NEVER(a_no_push_full, push && full, "job pushed into full queue")
  `TDMA_NEVER(a_no_pop_empty, pop && !rvalid, "job popped from empty queue")
  `TDMA_ASSERT(a_count_up, (push && !pop) |=> (count == $past(count) + 1'b1), "count did not rise")
  `TDMA_ASSERT(a_ptr_gap, (wr_ptr - rd_ptr) == count[tdma_pkg::QPTR_W-1:0], "pointers and count disagree")

endmodule

FILE: src/tdma_back.sv
// ----------------------------------------------------------------------------
// TDMA back end
// Serializes queued frame jobs into bytes with a running transmit CRC,
// through a registered output stage.
// ----------------------------------------------------------------------------
module tdma_back (
  input  logic           clk,
  input  logic           rst,
  input  tdma_pkg::cfg_t cfg,
  input  tdma_pkg::job_t q_data,
  input  logic           q_valid,
  output logic           pop,
  tdma_out_if.source     frames
);

  tdma_pkg::job_t cur;
  logic           busy;
  logic [4:0]     idx;
  logic [15:0]    crc;

  logic           ov;
  logic [7:0]     obyte;
  logic           olast;
  logic           okind;
  logic [15:0]    ogood;
  logic [15:0]    obad;

  logic [4:0]     body_len;
  logic [4:0]     last_idx;
  logic           load_out;
  logic           is_last;
  logic [15:0]    dst;
  logic [7:0]     code;
  logic [7:0]     body_byte;
  logic [7:0]     byte_sel;

  assign body_len = (cur.kind == tdma_pkg::KIND_ASSOC) ? tdma_pkg::ASSOC_BODY
                                                       : tdma_pkg::BEACON_BODY;
  assign last_idx = body_len + 5'd1;
  assign load_out = busy && (!ov || frames.ready);
  assign is_last  = (idx == last_idx);
  assign pop      = q_valid && (!busy || (load_out && is_last));
  assign dst      = (cur.kind == tdma_pkg::KIND_ASSOC) ? cur.requester : tdma_pkg::BROADCAST;
  assign code     = (cur.kind == tdma_pkg::KIND_ASSOC) ? tdma_pkg::ASSOC_CODE
                                                       : tdma_pkg::BEACON_CODE;

  // header bytes 0..10 share one layout (code and destination depend on kind); payload from byte 11 differs by kind
  always_comb begin
    case (idx)
      5'd0:    body_byte = cfg.frame_control_byte;
      5'd1:    body_byte = code;
      5'd2:    body_byte = cur.seq;
      5'd3:    body_byte = cfg.dest_pan_id[7:0];
      5'd4:    body_byte = cfg.dest_pan_id[15:8];
      5'd5:    body_byte = dst[7:0];
      5'd6:    body_byte = dst[15:8];
      5'd7:    body_byte = cfg.own_pan_id[7:0];
      5'd8:    body_byte = cfg.own_pan_id[15:8];
      5'd9:    body_byte = cfg.own_short_addr[7:0];
      5'd10:   body_byte = cfg.own_short_addr[15:8];
      5'd11:   body_byte = (cur.kind == tdma_pkg::KIND_ASSOC) ? cur.slot
                                                              : cfg.superframe_length[7:0];
      5'd12:   body_byte = cfg.superframe_length[15:8];
      5'd13:   body_byte = cfg.slot_total;
      5'd14:   body_byte = cur.stamp[7:0];
      5'd15:   body_byte = cur.stamp[15:8];
      5'd16:   body_byte = cur.stamp[23:16];
      5'd17:   body_byte = cur.stamp[31:24];
      default: body_byte = 8'd0;
    endcase
  end

  always_comb begin
    if (idx == body_len) begin
      byte_sel = crc[7:0];
    end else if (is_last) begin
      byte_sel = crc[15:8];
    end else begin
      byte_sel = body_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      obyte <= byte_sel;
      olast <= is_last;
      okind <= cur.kind;
      ogood <= cur.good;
      obad  <= cur.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 5'd0;
      crc  <= 16'd0;
      ov   <= 1'b0;
    end else begin
      if (load_out) begin
        ov  <= 1'b1;
        idx <= idx + 5'd1;
        if (idx < body_len) begin
          crc <= tdma_pkg::crc_byte(crc, body_byte);
        end
        if (is_last) begin
          busy <= 1'b0;
        end
      end else if (frames.ready) begin
        ov <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= 5'd0;
        crc  <= 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  assign frames.valid          = ov;
  assign frames.out_byte       = obyte;
  assign frames.out_last       = olast;
  assign frames.out_kind       = okind;
  assign frames.frames_counted = ogood;
  assign frames.crc_failures   = obad;

endmodule
